[hw/rtl/ack_retransmission_table_assert.svh]
// Assertion macros for the acknowledgement retransmission table.
// Included by files that check their own logic; no other dependencies.
`ifndef ACK_RETRANSMISSION_TABLE_ASSERT_SVH
`define ACK_RETRANSMISSION_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
`define ART_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ack_retransmission_table: assertion failed");
`define ART_ASSERT_NEVER(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("ack_retransmission_table: forbidden condition");
`else
`define ART_ASSERT(name, clk, rst, prop)
`define ART_ASSERT_NEVER(name, clk, rst, cond)
`endif

`endif

[hw/rtl/art_pkg.sv]
// Shared types and constants for the acknowledgement retransmission table.
// No dependencies; used by art_ctrl, art_dpath and the top level.
`timescale 1ns / 1ps

package art_pkg;

  localparam int SLOT_COUNT_DEF = 10;
  localparam logic [3:0] RETRY_RESET = 4'd5;

  localparam logic [1:0] OP_STORE  = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_POLL   = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  cmd_code;
    logic [3:0]  ack_kind;
    logic [47:0] sender_id;
    logic [47:0] receiver_id;
    logic [63:0] body;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  out_cmd;
    logic [3:0]  out_ack;
    logic [47:0] out_sender;
    logic [47:0] out_receiver;
    logic [3:0]  out_retries;
    logic [63:0] out_body;
  } out_item_t;

  // Slot contents kept in the payload memory
  typedef struct packed {
    logic [3:0]  ack;
    logic [47:0] sender;
    logic [47:0] receiver;
    logic [63:0] body;
  } slot_data_t;

  typedef struct packed {
    logic load_item;
    logic clear_idx;
    logic step_idx;
    logic apply;
    logic set_miss;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;
    logic last;
    logic out_free;
  } ctrl_sts_t;

endpackage

[hw/rtl/art_ctrl.sv]
// Controller state machine for the retransmission table.
// Depends on art_pkg; drives art_dpath through ctrl_cmd_t.
`timescale 1ns / 1ps

module art_ctrl
  import art_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          cmd.clear_idx = 1'b1;
          state_next    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // hold the index on a hit so the registered read matches it
        if (sts.hit) begin
          state_next = ST_APPLY;
        end else if (sts.last) begin
          cmd.set_miss = 1'b1;
          state_next   = ST_DONE;
        end else begin
          cmd.step_idx = 1'b1;
        end
      end
      ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/art_dpath.sv]
// Datapath for the retransmission table: slot storage, scan index,
// result and output registers, retry limit. Depends on art_pkg.
`timescale 1ns / 1ps

module art_dpath
  import art_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  in_item_t   in_item,
  input  logic       cfg_valid,
  input  logic [3:0] cfg_data,
  input  logic       out_ready,
  output logic       out_valid,
  output out_item_t  out_item,
  input  ctrl_cmd_t  cmd,
  output ctrl_sts_t  sts
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  in_item_t         item;
  logic [IDX_W-1:0] idx;
  logic [7:0]       cmd_q [SLOT_COUNT];
  logic [3:0]       retries_q [SLOT_COUNT];
  slot_data_t       mem [SLOT_COUNT];
  slot_data_t       rd_q;
  out_item_t        res;
  out_item_t        res_next;
  logic [3:0]       retry_limit;
  logic [7:0]       cur_cmd;
  logic [3:0]       cur_retries;
  logic [3:0]       store_retries;
  logic             match;

  assign cur_cmd       = cmd_q[idx];
  assign cur_retries   = retries_q[idx];
  assign store_retries = (retry_limit == 4'd0) ? 4'd1 : retry_limit;

  always_comb begin
    case (item.op)
      OP_STORE:  match = (cur_cmd == 8'd0) && (item.cmd_code != 8'd0);
      OP_REMOVE: match = (item.cmd_code != 8'd0) && (cur_cmd == item.cmd_code);
      OP_POLL:   match = (cur_cmd != 8'd0);
      default:   match = 1'b0;
    endcase
  end

  assign sts.hit      = match;
  assign sts.last     = (idx == LAST_IDX);
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_item;
    end
    if (cmd.clear_idx) begin
      idx <= '0;
    end else if (cmd.step_idx) begin
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit <= RETRY_RESET;
    end else if (cfg_valid) begin
      retry_limit <= cfg_data;
    end
  end

  // Payload memory: one write port, one registered read at the scan index
  always_ff @(posedge clk) begin
    rd_q <= mem[idx];
    if (cmd.apply && item.op == OP_STORE) begin
      mem[idx] <= '{ack: item.ack_kind, sender: item.sender_id,
                     receiver: item.receiver_id, body: item.body};
    end
  end

  // Occupancy: a nonzero command code marks a slot in use
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        cmd_q[i] <= 8'd0;
      end
    end else if (cmd.apply) begin
      case (item.op)
        OP_STORE: begin
          cmd_q[idx] <= item.cmd_code;
        end
        OP_REMOVE: begin
          cmd_q[idx] <= 8'd0;
        end
        OP_POLL: begin
          if (cur_retries <= 4'd1) begin
            cmd_q[idx] <= 8'd0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      if (item.op == OP_STORE) begin
        retries_q[idx] <= store_retries;
      end else if (item.op == OP_POLL) begin
        retries_q[idx] <= cur_retries - 4'd1;
      end
    end
  end

  always_comb begin
    res_next = '0;
    if (cmd.set_miss) begin
      res_next.status = !(item.op == OP_STORE && item.cmd_code == 8'd0);
    end else if (item.op == OP_POLL) begin
      res_next.out_cmd      = cur_cmd;
      res_next.out_ack      = rd_q.ack;
      res_next.out_sender   = rd_q.sender;
      res_next.out_receiver = rd_q.receiver;
      res_next.out_retries  = cur_retries;
      res_next.out_body     = rd_q.body;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_miss || cmd.apply) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_item <= res;
    end
  end

endmodule

[hw/rtl/ack_retransmission_table.sv]
// Acknowledgement retransmission table: holds up to SLOT_COUNT messages that
// wait for an acknowledgement and serves store, remove-on-ack and poll
// requests, one result per request. A request is worked on alone: it walks the
// slots one per cycle from slot 0 until it finds its slot or tests the last
// one. A hit then passes through an apply step that updates the slot and
// loads the result register; a miss loads the result register directly.
// The result moves to the output register once that is free, so a request
// also waits while the previous result waits for out_ready. A new request is
// taken while the previous result still waits in the output register. The
// retry limit register may be written at any time the block is idle; there
// is no clearing pass after reset.
// Depends on art_pkg, art_ctrl and art_dpath.
`timescale 1ns / 1ps

module ack_retransmission_table
  import art_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data
);

`include "ack_retransmission_table_assert.svh"

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  art_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  art_dpath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cmd       (cmd),
    .sts       (sts)
  );

  `ART_ASSERT(a_busy_after_accept, clk, rst, (in_valid && in_ready) |=> !in_ready)
  `ART_ASSERT(a_no_result_overwrite, clk, rst, cmd.load_out |-> (!out_valid || out_ready))
  `ART_ASSERT_NEVER(a_scan_in_range, clk, rst, cmd.step_idx && sts.last)

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for ack_retransmission_table: directed and random
// store, remove and poll requests checked against a slot-table predictor.
// Depends on art_pkg and the ack_retransmission_table RTL.

module tb_top;
  import art_pkg::*;

  localparam int         SLOTS        = SLOT_COUNT_DEF;
  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         PHASES       = 10;
  localparam int         PHASE_ITEMS  = 150;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         DRAIN_CYCLES = 30;
  localparam int         STALL_LIMIT  = 5000;
  localparam int         MAX_REPORTS  = 50;

  typedef struct packed {
    logic [7:0]  cmd;
    logic [3:0]  ack;
    logic [47:0] sender;
    logic [47:0] receiver;
    logic [3:0]  retries;
    logic [63:0] body;
  } entry_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_item_t   in_item   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [3:0] cfg_data  = 4'd0;

  ack_retransmission_table #(
    .SLOT_COUNT(SLOTS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // Predictor state
  entry_t     msg_table [SLOTS];
  logic [3:0] retry_shadow;

  in_item_t   pending_q [$];
  out_item_t  expected_q [$];

  int fail_count = 0;
  int n_store = 0, n_remove = 0, n_poll = 0, n_other = 0;
  int n_results = 0, n_cfg = 0;

  bit calm = 1'b0;
  bit in_taken = 1'b0;
  int in_gap = 0;
  int hold_req = 0, hold_done = 0, hold_left = 0, out_gap = 0;
  int idle_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int idle_len(bit quiet);
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Apply one request to the table copy and return the result it produces
  function automatic out_item_t table_apply(in_item_t req);
    out_item_t res;
    bit        done;
    res        = '0;
    res.status = 1'b1;
    done       = 1'b0;
    case (req.op)
      OP_STORE: begin
        if (req.cmd_code == 8'd0) begin
          res.status = 1'b0;
        end else begin
          for (int k = 0; k < SLOTS && !done; k++) begin
            if (msg_table[k].cmd == 8'd0) begin
              done                  = 1'b1;
              res.status            = 1'b0;
              msg_table[k].cmd      = req.cmd_code;
              msg_table[k].ack      = req.ack_kind;
              msg_table[k].sender   = req.sender_id;
              msg_table[k].receiver = req.receiver_id;
              msg_table[k].body     = req.body;
              msg_table[k].retries  = (retry_shadow == 4'd0) ? 4'd1 : retry_shadow;
            end
          end
        end
      end
      OP_REMOVE: begin
        if (req.cmd_code != 8'd0) begin
          for (int k = 0; k < SLOTS && !done; k++) begin
            if (msg_table[k].cmd == req.cmd_code) begin
              done         = 1'b1;
              res.status   = 1'b0;
              msg_table[k] = '0;
            end
          end
        end
      end
      OP_POLL: begin
        for (int k = 0; k < SLOTS && !done; k++) begin
          if (msg_table[k].cmd != 8'd0) begin
            done             = 1'b1;
            res.status       = 1'b0;
            res.out_cmd      = msg_table[k].cmd;
            res.out_ack      = msg_table[k].ack;
            res.out_sender   = msg_table[k].sender;
            res.out_receiver = msg_table[k].receiver;
            res.out_retries  = msg_table[k].retries;
            res.out_body     = msg_table[k].body;
            // drop the slot once its last retry is used
            if (msg_table[k].retries <= 4'd1) begin
              msg_table[k] = '0;
            end else begin
              msg_table[k].retries = msg_table[k].retries - 4'd1;
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic in_item_t make_msg(logic [1:0] op, logic [7:0] cmd, logic [3:0] ack,
                                        logic [47:0] snd, logic [47:0] rcv, logic [63:0] body);
    in_item_t m;
    m.op          = op;
    m.cmd_code    = cmd;
    m.ack_kind    = ack;
    m.sender_id   = snd;
    m.receiver_id = rcv;
    m.body        = body;
    return m;
  endfunction

  // Mostly well-formed traffic on a small pool of command codes so that
  // removes hit, the table fills and polls run retries out.
  function automatic in_item_t rand_msg();
    in_item_t m;
    int       roll;
    roll = $urandom_range(0, 99);
    if (roll < 40)      m.op = OP_STORE;
    else if (roll < 65) m.op = OP_REMOVE;
    else if (roll < 98) m.op = OP_POLL;
    else                m.op = OP_UNUSED;
    roll = $urandom_range(0, 99);
    if (roll < 70)      m.cmd_code = 8'($urandom_range(1, 12));
    else if (roll < 78) m.cmd_code = 8'd0;
    else                m.cmd_code = 8'($urandom);
    m.ack_kind    = 4'($urandom);
    m.sender_id   = 48'({$urandom, $urandom});
    m.receiver_id = 48'({$urandom, $urandom});
    m.body        = {$urandom, $urandom};
    return m;
  endfunction

  function automatic in_item_t rand_store(logic [7:0] cmd);
    return make_msg(OP_STORE, cmd, 4'($urandom), 48'({$urandom, $urandom}),
                    48'({$urandom, $urandom}), {$urandom, $urandom});
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_retry(logic [3:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    retry_shadow = value;
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Request driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        in_item  <= pending_q.pop_front();
        in_valid <= 1'b1;
        in_gap   = idle_len(calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Predict on every accepted request
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      expected_q.push_back(table_apply(in_item));
      in_taken = 1'b1;
      case (in_item.op)
        OP_STORE:  n_store++;
        OP_REMOVE: n_remove++;
        OP_POLL:   n_poll++;
        default:   n_other++;
      endcase
    end
  end

  // Result receiver with random stalls and one long hold-off on demand
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_done != hold_req) begin
      hold_done = hold_req;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      out_gap = idle_len(calm);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual %h", $time, out_item);
      end else begin
        want = expected_q.pop_front();
        check_field("status", 64'(want.status), 64'(out_item.status));
        check_field("out_cmd", 64'(want.out_cmd), 64'(out_item.out_cmd));
        check_field("out_ack", 64'(want.out_ack), 64'(out_item.out_ack));
        check_field("out_sender", 64'(want.out_sender), 64'(out_item.out_sender));
        check_field("out_receiver", 64'(want.out_receiver), 64'(out_item.out_receiver));
        check_field("out_retries", 64'(want.out_retries), 64'(out_item.out_retries));
        check_field("out_body", want.out_body, out_item.out_body);
      end
    end
  end

  // Watchdog on lack of progress
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, expected_q.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [3:0] limits [6];
    limits = '{4'd15, 4'd1, 4'd3, 4'd0, 4'd8, 4'd2};
    retry_shadow = RETRY_RESET;
    for (int k = 0; k < SLOTS; k++) msg_table[k] = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table, code zero, unused op, extremes, full table
    pending_q.push_back(make_msg(OP_POLL, 8'd0, 4'd0, 48'd0, 48'd0, 64'd0));
    pending_q.push_back(make_msg(OP_REMOVE, 8'd0, 4'd0, 48'd0, 48'd0, 64'd0));
    pending_q.push_back(make_msg(OP_REMOVE, 8'h55, 4'd0, 48'd0, 48'd0, 64'd0));
    pending_q.push_back(make_msg(OP_STORE, 8'd0, 4'hf, '1, '1, '1));
    pending_q.push_back(make_msg(OP_UNUSED, 8'hff, 4'hf, '1, '1, '1));
    pending_q.push_back(make_msg(OP_STORE, 8'hff, 4'hf, '1, '1, '1));
    for (int k = 1; k < SLOTS; k++) pending_q.push_back(rand_store(8'(k)));
    pending_q.push_back(make_msg(OP_STORE, 8'h80, 4'h3, 48'd0, 48'd0, 64'd0));
    pending_q.push_back(make_msg(OP_REMOVE, 8'hff, 4'd0, 48'd0, 48'd0, 64'd0));
    pending_q.push_back(make_msg(OP_POLL, 8'd0, 4'd0, 48'd0, 48'd0, 64'd0));
    pending_q.push_back(make_msg(OP_REMOVE, 8'd0, 4'd0, 48'd0, 48'd0, 64'd0));
    pending_q.push_back(make_msg(OP_STORE, 8'h22, 4'd0, 48'd0, 48'd0, 64'd0));
    pending_q.push_back(make_msg(OP_POLL, 8'd0, 4'd0, 48'd0, 48'd0, 64'd0));
    wait_idle();

    // Zero limit stores a single retry; the next poll frees the slot
    write_retry(4'd0);
    pending_q.push_back(make_msg(OP_REMOVE, 8'h22, 4'd0, 48'd0, 48'd0, 64'd0));
    pending_q.push_back(rand_store(8'h33));
    pending_q.push_back(make_msg(OP_POLL, 8'd0, 4'd0, 48'd0, 48'd0, 64'd0));
    pending_q.push_back(make_msg(OP_POLL, 8'd0, 4'd0, 48'd0, 48'd0, 64'd0));
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      write_retry(p < 6 ? limits[p] : 4'($urandom_range(0, 15)));
      calm = (p == 2) || (p == 5);
      for (int j = 0; j < PHASE_ITEMS; j++) pending_q.push_back(rand_msg());
      // hold results back while requests keep coming, so the block backs up
      if (p == 2) hold_req++;
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d stores, %0d removes, %0d polls, %0d unused ops; %0d results checked",
             n_store, n_remove, n_poll, n_other, n_results);
    $display("Retry limit rewritten %0d times, with one long result hold-off", n_cfg);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
